[rtl/core/hdlc_bit_deframer_with_fcs_unit_assert.svh]
// assertion macros for the hdlc bit deframer
// used by the top level only; expects a clock named clk and a reset named rst
`ifndef HDLC_BIT_DEFRAMER_WITH_FCS_UNIT_ASSERT_SVH
`define HDLC_BIT_DEFRAMER_WITH_FCS_UNIT_ASSERT_SVH

// same-cycle implication
`define HBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hbd_pkg.sv]
// shared types, constants and the crc octet function for the hdlc bit deframer
// no dependencies
package hbd_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int OCT_W        = 8;
  localparam int RUN_W        = 3;
  localparam int HOLD_W       = 15;
  localparam int HCNT_W       = 4;
  localparam int CNT_W        = 16;
  localparam int CRC_W        = 16;
  localparam int CFG_W        = 8;

  localparam logic [CRC_W-1:0]  CRC_POLY         = 16'h8408;
  localparam logic [CRC_W-1:0]  CRC_PRESET       = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_RESIDUE      = 16'hF0B8;
  localparam logic [HCNT_W-1:0] DELAY_BITS       = 4'd7;
  localparam logic [HCNT_W-1:0] FULL_HOLD        = 4'd15;
  localparam logic [CNT_W-1:0]  OCTETS_MAX       = 16'hFFFF;
  localparam logic [CFG_W-1:0]  MIN_OCTETS_RESET = 8'd17;
  localparam logic [RUN_W-1:0]  RUN_STUFF        = 3'd5;
  localparam logic [RUN_W-1:0]  RUN_FLAG         = 3'd6;
  localparam logic [RUN_W-1:0]  RUN_ABORT        = 3'd7;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FCS_ERR   = 3'd1,
    ST_NOT_WHOLE = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_ABORTED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [RUN_W-1:0]        ones_run;
    logic                    in_frame;
    logic                    waiting;
    logic [SAMPLE_WIDTH-1:0] start_sample;
    logic [HOLD_W-1:0]       held;
    logic [HCNT_W-1:0]       hcnt;
    logic [CNT_W-1:0]        octs;
    logic [CRC_W-1:0]        crc;
  } state_t;

  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [OCT_W-1:0]        octet;
    status_t                 status;
    logic [SAMPLE_WIDTH-1:0] start_sample;
    logic [SAMPLE_WIDTH-1:0] end_sample;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_octet(input logic [CRC_W-1:0] crc_in,
                                                  input logic [OCT_W-1:0] octet);
    logic [CRC_W-1:0] c;
    c = crc_in;
    for (int k = 0; k < OCT_W; k++) begin
      if (c[0] != octet[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/hbd_line_if.sv]
// input channel: one decoded line bit and its sample index per item
// depends on hbd_pkg
interface hbd_line_if;
  logic                            valid;
  logic                            ready;
  logic                            data_bit;
  logic [hbd_pkg::SAMPLE_WIDTH-1:0] sample_index;

  modport source (output valid, output data_bit, output sample_index, input ready);
  modport sink (input valid, input data_bit, input sample_index, output ready);
endinterface

[rtl/core/hbd_frame_if.sv]
// output channel: data octet or frame end item
// depends on hbd_pkg
interface hbd_frame_if;
  logic                            valid;
  logic                            ready;
  logic                            item_kind;
  logic [hbd_pkg::OCT_W-1:0]        octet_value;
  logic [2:0]                      frame_status;
  logic [hbd_pkg::SAMPLE_WIDTH-1:0] start_sample;
  logic [hbd_pkg::SAMPLE_WIDTH-1:0] end_sample;

  modport source (output valid, output item_kind, output octet_value, output frame_status,
                  output start_sample, output end_sample, input ready);
  modport sink (input valid, input item_kind, input octet_value, input frame_status,
                input start_sample, input end_sample, output ready);
endinterface

[rtl/core/hbd_step.sv]
// per-bit next state and result: run counting, destuffing, flag and abort
// detection, seven-bit hold, octet assembly and crc; depends on hbd_pkg
module hbd_step (
  input  hbd_pkg::state_t                  cur,
  input  logic                             line_bit,
  input  logic [hbd_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [hbd_pkg::CFG_W-1:0]        min_octets,
  output hbd_pkg::state_t                  nxt,
  output hbd_pkg::result_t                 res
);

  always_comb begin
    logic                         accept;
    logic [hbd_pkg::HOLD_W-1:0]   held_set;
    logic [hbd_pkg::HCNT_W-1:0]   cnt_inc;
    nxt      = cur;
    res      = '0;
    accept   = 1'b0;
    held_set = cur.held | (hbd_pkg::HOLD_W'(line_bit) << cur.hcnt);
    cnt_inc  = cur.hcnt + 4'd1;

    if (line_bit) begin
      if (cur.ones_run == hbd_pkg::RUN_FLAG) begin
        // seventh one: abort
        nxt.ones_run = hbd_pkg::RUN_ABORT;
        if (cur.in_frame && cur.octs != '0) begin
          res.valid        = 1'b1;
          res.kind         = hbd_pkg::KIND_END;
          res.status       = hbd_pkg::ST_ABORTED;
          res.start_sample = cur.start_sample;
          res.end_sample   = sample;
        end
        nxt.in_frame = 1'b0;
        nxt.held     = '0;
        nxt.hcnt     = '0;
        nxt.octs     = '0;
        nxt.crc      = hbd_pkg::CRC_PRESET;
      end else begin
        if (cur.ones_run != hbd_pkg::RUN_ABORT) begin
          nxt.ones_run = cur.ones_run + 3'd1;
        end
        accept = cur.in_frame;
      end
    end else begin
      nxt.ones_run = '0;
      if (cur.ones_run == hbd_pkg::RUN_FLAG) begin
        // flag closes the frame in progress and opens a new one
        if (cur.in_frame && cur.octs != '0) begin
          res.valid        = 1'b1;
          res.kind         = hbd_pkg::KIND_END;
          res.start_sample = cur.start_sample;
          res.end_sample   = sample;
          if (cur.hcnt > hbd_pkg::DELAY_BITS) begin
            res.status = hbd_pkg::ST_NOT_WHOLE;
          end else if (cur.octs < {8'd0, min_octets}) begin
            res.status = hbd_pkg::ST_TOO_SHORT;
          end else if (cur.crc != hbd_pkg::CRC_RESIDUE) begin
            res.status = hbd_pkg::ST_FCS_ERR;
          end else begin
            res.status = hbd_pkg::ST_OK;
          end
        end
        nxt.in_frame = 1'b1;
        nxt.waiting  = 1'b1;
        nxt.held     = '0;
        nxt.hcnt     = '0;
        nxt.octs     = '0;
        nxt.crc      = hbd_pkg::CRC_PRESET;
      end else if (cur.ones_run != hbd_pkg::RUN_STUFF && cur.ones_run != hbd_pkg::RUN_ABORT) begin
        accept = cur.in_frame;
      end
    end

    if (accept) begin
      if (cur.waiting) begin
        nxt.start_sample = sample;
        nxt.waiting      = 1'b0;
      end
      if (cnt_inc >= hbd_pkg::FULL_HOLD) begin
        nxt.held = {8'd0, held_set[hbd_pkg::HOLD_W-1:hbd_pkg::OCT_W]};
        nxt.hcnt = hbd_pkg::DELAY_BITS;
        nxt.crc  = hbd_pkg::crc_octet(cur.crc, held_set[hbd_pkg::OCT_W-1:0]);
        if (cur.octs != hbd_pkg::OCTETS_MAX) begin
          nxt.octs = cur.octs + 16'd1;
        end
        res.valid        = 1'b1;
        res.kind         = hbd_pkg::KIND_DATA;
        res.octet        = held_set[hbd_pkg::OCT_W-1:0];
        res.status       = hbd_pkg::ST_OK;
        res.start_sample = cur.waiting ? sample : cur.start_sample;
        res.end_sample   = '0;
      end else begin
        nxt.held = held_set;
        nxt.hcnt = cnt_inc;
      end
    end
  end

endmodule

[rtl/core/hdlc_bit_deframer_with_fcs_unit.sv]
// hdlc bit deframer with crc-16 fcs check: input register, per-bit step logic,
// output register; depends on hbd_pkg, hbd_line_if, hbd_frame_if, hbd_step
// path: an accepted input item is held in the input register, and its result, if any, in the output register
// throughput: one item per cycle while results are taken, set by the combinational step logic
// reset: synchronous, clears deframer state, crc to all ones, min octets to 17
module hdlc_bit_deframer_with_fcs_unit (
  input  logic                      clk,
  input  logic                      rst,
  hbd_line_if.sink                  line,
  hbd_frame_if.source               frame,
  input  logic                      cfg_wr_en,
  input  logic [hbd_pkg::CFG_W-1:0] cfg_wr_data
);

  `include "hdlc_bit_deframer_with_fcs_unit_assert.svh"

  hbd_pkg::state_t                  st;
  hbd_pkg::state_t                  st_next;
  hbd_pkg::result_t                 res;
  hbd_pkg::result_t                 o_item;
  logic [hbd_pkg::CFG_W-1:0]        min_octets;
  logic                             s1_valid;
  logic                             s1_bit;
  logic [hbd_pkg::SAMPLE_WIDTH-1:0] s1_sample;
  logic                             o_valid;
  logic                             advance;

  assign advance    = s1_valid && (!o_valid || frame.ready);
  assign line.ready = !s1_valid || advance;

  hbd_step u_step (
    .cur        (st),
    .line_bit   (s1_bit),
    .sample     (s1_sample),
    .min_octets (min_octets),
    .nxt        (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_octets <= hbd_pkg::MIN_OCTETS_RESET;
    end else if (cfg_wr_en) begin
      min_octets <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line.ready) begin
      s1_valid <= line.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (line.valid && line.ready) begin
      s1_bit    <= line.data_bit;
      s1_sample <= line.sample_index;
    end
  end

  // deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.ones_run     <= '0;
      st.in_frame     <= 1'b0;
      st.waiting      <= 1'b0;
      st.start_sample <= '0;
      st.held         <= '0;
      st.hcnt         <= '0;
      st.octs         <= '0;
      st.crc          <= hbd_pkg::CRC_PRESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= res.valid;
    end else if (frame.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      o_item <= res;
    end
  end

  assign frame.valid        = o_valid;
  assign frame.item_kind    = o_item.kind;
  assign frame.octet_value  = o_item.octet;
  assign frame.frame_status = o_item.status;
  assign frame.start_sample = o_item.start_sample;
  assign frame.end_sample   = o_item.end_sample;

  `HBD_ASSERT_NOW(a_abort_outside, st.ones_run == hbd_pkg::RUN_ABORT, !st.in_frame,
                  "abort run in frame")
  `HBD_ASSERT_NOW(a_waiting_empty, st.waiting, st.hcnt == '0 && st.octs == '0,
                  "bits held before first bit")
  `HBD_ASSERT_NOW(a_crc_preset, st.octs == '0, st.crc == hbd_pkg::CRC_PRESET,
                  "crc moved with no octet")
  `HBD_ASSERT_NEXT(a_octet_counted, advance && res.valid && res.kind == hbd_pkg::KIND_DATA,
                   st.octs != '0 && o_valid, "data octet not counted")

endmodule
